// ===== rtl/core/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants for the sprite frame sequencer: command codes,
// configuration register indexes, field widths and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfs_pkg;

    // field widths
    localparam int FRAME_W   = 6;
    localparam int COUNT_W   = 7;
    localparam int DELAY_W   = 16;
    localparam int TIME_W    = 32;
    localparam int LOOPS_W   = 16;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // frame slots addressable by the index, and the frame count cap
    localparam int FRAME_SLOTS = 64;
    localparam int MAX_FRAMES  = 64;
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        COUNT_W'((MAX_FRAMES < FRAME_SLOTS) ? MAX_FRAMES : FRAME_SLOTS);

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd150;
    localparam logic [LOOPS_W-1:0] LOOP_MAX    = '1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STOP      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP_AT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CONTINUE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESTART   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SET_FRAME = 3'd5;
    localparam logic [CMD_W-1:0] CMD_WR_DELAY  = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_TABLE   = 2'd2;

    // one result record
    typedef struct packed {
        logic [FRAME_W-1:0] current_frame;
        logic               running;
        logic               finished;
        logic [LOOPS_W-1:0] loops_done;
    } t_result;

endpackage

// ===== rtl/core/sprite_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// sprite_frame_sequencer
// Animation frame sequencer: ticks advance the shown frame once its delay
// has elapsed, other commands stop, arm a stop frame, continue, restart,
// set the frame or write the per-frame delay table.
//
//   channel  direction  handshake                      payload
//   in       input      i_in_valid / o_in_stall        i_cmd, i_now_ms,
//                                                      i_frame_arg, i_delay_value
//   out      output     o_out_valid / i_out_stall      o_current_frame, o_running,
//                                                      o_finished, o_loops_done
//   cfg      input      i_cfg_we                       i_cfg_index, i_cfg_data
//
// One command per cycle while o_in_stall is low; results are queued in order.
// The delay table memory is read every cycle at the frame index that the
// state is about to hold, so the entry of the shown frame is always ready.
// Reset is synchronous; the delay table has no reset and no clearing pass.
// A two-entry result queue absorbs output stalls; o_in_stall rises only
// when both entries hold results not yet taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_frame_sequencer
    import sfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // commands
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic [FRAME_W-1:0]    i_frame_arg,
    input  logic [DELAY_W-1:0]    i_delay_value,
    // results
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [FRAME_W-1:0]    o_current_frame,
    output logic                  o_running,
    output logic                  o_finished,
    output logic [LOOPS_W-1:0]    o_loops_done
);

    // configuration registers
    logic [COUNT_W-1:0] r_frame_count;
    logic [DELAY_W-1:0] r_frame_delay;
    logic               r_use_table;

    // sequencer state
    logic [FRAME_W-1:0] r_frame_index, n_frame_index;
    logic               r_run,         n_run;
    logic               r_stop_armed,  n_stop_armed;
    logic [FRAME_W-1:0] r_stop_frame,  n_stop_frame;
    logic [TIME_W-1:0]  r_last_ms,     n_last_ms;
    logic [LOOPS_W-1:0] r_loops,       n_loops;

    // delay table and its registered read port
    logic [DELAY_W-1:0] r_delay_mem [FRAME_SLOTS];
    logic [DELAY_W-1:0] r_rd_data;

    logic               q_full;
    logic               in_acc;
    logic               tbl_we;
    logic [COUNT_W-1:0] eff_count;
    logic               arg_ok;
    logic [DELAY_W-1:0] cur_delay;
    logic [TIME_W:0]    due_ms;
    logic               delay_done;
    logic [COUNT_W-1:0] next_index;
    t_result            res;
    t_result            out_res;

    assign o_in_stall = q_full;
    assign in_acc     = i_in_valid && !q_full;
    assign tbl_we     = in_acc && (i_cmd == CMD_WR_DELAY);

    assign eff_count  = (r_frame_count > COUNT_CAP) ? COUNT_CAP : r_frame_count;
    assign arg_ok     = {1'b0, i_frame_arg} < eff_count;
    assign cur_delay  = r_use_table ? r_rd_data : r_frame_delay;
    assign due_ms     = {1'b0, r_last_ms} + {{(TIME_W + 1 - DELAY_W){1'b0}}, cur_delay};
    assign delay_done = due_ms <= {1'b0, i_now_ms};
    assign next_index = {1'b0, r_frame_index} + 7'd1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_frame_delay <= DELAY_RESET;
            r_use_table   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[COUNT_W-1:0];
                CFG_FRAME_DELAY: r_frame_delay <= i_cfg_data[DELAY_W-1:0];
                CFG_USE_TABLE:   r_use_table   <= i_cfg_data[0];
                default:         r_use_table   <= r_use_table;
            endcase
        end
    end

    // command execution
    always_comb begin
        n_frame_index = r_frame_index;
        n_run         = r_run;
        n_stop_armed  = r_stop_armed;
        n_stop_frame  = r_stop_frame;
        n_last_ms     = r_last_ms;
        n_loops       = r_loops;
        if (in_acc) begin
            unique case (i_cmd)
                CMD_TICK: begin
                    if ((eff_count != '0) && r_run) begin
                        if (r_stop_armed && (r_stop_frame == r_frame_index)) begin
                            n_run = 1'b0;
                        end else if (delay_done) begin
                            n_last_ms = i_now_ms;
                            if (next_index >= eff_count) begin
                                n_frame_index = '0;
                                if (r_loops != LOOP_MAX) begin
                                    n_loops = r_loops + 16'd1;
                                end
                            end else begin
                                n_frame_index = next_index[FRAME_W-1:0];
                            end
                        end
                    end
                end
                CMD_STOP: begin
                    n_run = 1'b0;
                end
                CMD_STOP_AT: begin
                    if (arg_ok) begin
                        n_stop_armed = 1'b1;
                        n_stop_frame = i_frame_arg;
                    end
                end
                CMD_CONTINUE: begin
                    if (!r_run) begin
                        n_stop_armed = 1'b0;
                        n_run        = 1'b1;
                    end
                end
                CMD_RESTART: begin
                    n_frame_index = '0;
                    n_stop_armed  = 1'b0;
                    n_run         = 1'b1;
                    n_loops       = '0;
                end
                CMD_SET_FRAME: begin
                    if (arg_ok) begin
                        n_frame_index = i_frame_arg;
                    end
                end
                default: begin
                    n_run = r_run;
                end
            endcase
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_index <= '0;
            r_run         <= 1'b1;
            r_stop_armed  <= 1'b0;
            r_stop_frame  <= '0;
            r_last_ms     <= '0;
            r_loops       <= '0;
        end else begin
            r_frame_index <= n_frame_index;
            r_run         <= n_run;
            r_stop_armed  <= n_stop_armed;
            r_stop_frame  <= n_stop_frame;
            r_last_ms     <= n_last_ms;
            r_loops       <= n_loops;
        end
    end

    // delay table: write on command, read at the upcoming frame index,
    // with the same-cycle write forwarded to the read register
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_delay_mem[i_frame_arg] <= i_delay_value;
        end
        if (tbl_we && (i_frame_arg == n_frame_index)) begin
            r_rd_data <= i_delay_value;
        end else begin
            r_rd_data <= r_delay_mem[n_frame_index];
        end
    end

    // result of the accepted command
    always_comb begin
        res.current_frame = n_frame_index;
        res.running       = n_run;
        res.finished      = (n_loops != '0);
        res.loops_done    = n_loops;
    end

    sfs_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_acc),
        .i_push_data (res),
        .o_full      (q_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (out_res)
    );

    assign o_current_frame = out_res.current_frame;
    assign o_running       = out_res.running;
    assign o_finished      = out_res.finished;
    assign o_loops_done    = out_res.loops_done;

    // frame state moves only on a transfer
    a_frame_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_frame_index))
        else $error("frame index changed without a command transfer");

    // loop count stays saturated until a restart
    a_loop_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_loops == LOOP_MAX) && !(in_acc && (i_cmd == CMD_RESTART))
        |=> r_loops == LOOP_MAX)
        else $error("loop count left saturation without restart");

    // table write to the upcoming frame is seen by the read register
    a_tbl_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_we && (i_frame_arg == n_frame_index) |=> r_rd_data == $past(i_delay_value))
        else $error("delay table forwarding mismatch");

    // tick at the armed stop frame halts the sequence
    a_stop_at: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_cmd == CMD_TICK) && r_run && (eff_count != '0) && r_stop_armed
        && (r_stop_frame == r_frame_index) |=> !r_run)
        else $error("sequence ran past armed stop frame");

endmodule

// ===== rtl/core/sfs_out_queue.sv =====
// ----------------------------------------------------------------------------
// sfs_out_queue
// Two-entry result queue that decouples the command side from a stalling
// result consumer; full while both entries hold results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfs_out_queue
    import sfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_data,
    output logic    o_full,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out_data
);

    t_result    r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop         = (r_cnt != 2'd0) && !i_out_stall;
    assign o_full      = (r_cnt == 2'd2);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q[r_rd_ptr];

    // payload storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("result pushed into full queue");

    // fill count never exceeds two entries
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result queue count out of range");

endmodule
